### rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types for the quadratic root solver: the code for the kind of roots.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  typedef enum logic [1:0] {
    KIND_A_ZERO      = 2'd0,
    KIND_DOUBLE_ZERO = 2'd1,
    KIND_REAL        = 2'd2,
    KIND_COMPLEX     = 2'd3
  } kind_e;

endpackage

`default_nettype wire

### rtl/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs_coef_if / qrs_root_if
// Valid/ready channels for the coefficient set and the root result.
// ----------------------------------------------------------------------------
`default_nettype none

interface qrs_coef_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coef_a;
  logic signed [WORD_BITS-1:0] coef_b;
  logic signed [WORD_BITS-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  root_kind;
  logic signed [WORD_BITS-1:0] first_value;
  logic signed [WORD_BITS-1:0] second_value;
  logic                        saturated;

  modport source (output valid, root_kind, first_value, second_value, saturated,
                  input ready);
  modport sink   (input valid, root_kind, first_value, second_value, saturated,
                  output ready);
endinterface

`default_nettype wire

### rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients.
//
// A coefficient set arrives as one transaction on coef_i and yields exactly
// one transaction on root_o: the kind of roots and two fixed-point values,
// clipped to the word range with a flag when a quotient overflows.
// The datapath is a chain of cells: two stages form the discriminant, one
// square-root cell per root bit (WORD_BITS+1 cells), one register forms the
// numerators, and one divider cell per quotient bit (WORD_BITS+2+FRAC_BITS
// cells, two lanes) precede the output register.
// One transaction is accepted in every cycle unless the receiver stalls.
// When the receiver stalls with a result waiting, the whole chain holds and
// coef_i.ready falls; no transaction is lost. Reset empties the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qrs_coef_if.sink  coef_i,
  qrs_root_if.source root_o
);

  localparam int W    = WORD_BITS;
  localparam int SW   = W + 1;
  localparam int NMW  = W + 2;
  localparam int NW   = NMW + FRAC_BITS;
  localparam int DW   = W + 1;
  localparam int SSW  = 2 + 1 + (W + 1) + DW;
  localparam int L1W  = 3;

  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || root_o.ready;
  assign coef_i.ready = en;

  // Stage 1: magnitudes and products.
  logic [W-1:0]   amag, bmag, cmag;
  logic           v1_q;
  logic [2*W-1:0] b2_q, ac_q;
  logic           sdiff_q, dneg_sign_q;
  logic [W:0]     nb_q;
  logic [DW-1:0]  dmag_q;
  qrs_pkg::kind_e kind1_q, kind1_d;

  always_comb begin
    amag = coef_i.coef_a[W-1] ? (~coef_i.coef_a + 1'b1) : coef_i.coef_a;
    bmag = coef_i.coef_b[W-1] ? (~coef_i.coef_b + 1'b1) : coef_i.coef_b;
    cmag = coef_i.coef_c[W-1] ? (~coef_i.coef_c + 1'b1) : coef_i.coef_c;
    if (coef_i.coef_a == '0) begin
      kind1_d = qrs_pkg::KIND_A_ZERO;
    end else if (coef_i.coef_b == '0 && coef_i.coef_c == '0) begin
      kind1_d = qrs_pkg::KIND_DOUBLE_ZERO;
    end else begin
      kind1_d = qrs_pkg::KIND_REAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= coef_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q        <= bmag * bmag;
      ac_q        <= amag * cmag;
      sdiff_q     <= coef_i.coef_a[W-1] ^ coef_i.coef_c[W-1];
      dneg_sign_q <= coef_i.coef_a[W-1];
      nb_q        <= -{coef_i.coef_b[W-1], coef_i.coef_b};
      dmag_q      <= {amag, 1'b0};
      kind1_q     <= kind1_d;
    end
  end

  // Stage 2: magnitude and sign of the discriminant.
  logic [2*SW-1:0] b2x, px, dabs;
  logic            dneg;
  logic            v2_q;
  logic [2*SW-1:0] dabs_q;
  logic [SSW-1:0]  side2_q;
  qrs_pkg::kind_e  kind2;

  always_comb begin
    b2x  = {2'b00, b2_q};
    px   = {ac_q, 2'b00};
    dneg = !sdiff_q && (b2x < px);
    if (sdiff_q) begin
      dabs = b2x + px;
    end else if (dneg) begin
      dabs = px - b2x;
    end else begin
      dabs = b2x - px;
    end
    kind2 = (kind1_q == qrs_pkg::KIND_REAL && dneg) ? qrs_pkg::KIND_COMPLEX : kind1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dabs_q  <= dabs;
      side2_q <= {kind2, dneg_sign_q, nb_q, dmag_q};
    end
  end

  // Square-root chain.
  logic              sq_v    [0:SW];
  logic [2*SW-1:0]   sq_rad  [0:SW];
  logic [SW+2:0]     sq_rem  [0:SW];
  logic [SW-1:0]     sq_root [0:SW];
  logic [SSW-1:0]    sq_side [0:SW];

  assign sq_v[0]    = v2_q;
  assign sq_rad[0]  = dabs_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side2_q;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .RootBits(SW),
      .SideBits(SSW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sq_v[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .valid_o(sq_v[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // Numerator stage.
  logic [1:0]     kind3;
  logic           den_neg3;
  logic [W:0]     nb3;
  logic [DW-1:0]  dmag3;
  logic [W+2:0]   nbx, sx, n1, n2, m1, m2;
  logic           v3_q;
  logic [NW-1:0]  num1_q, num2_q;
  logic [DW-1:0]  dmag3_q;
  logic [L1W-1:0] side3a_q;
  logic           neg2_q;

  always_comb begin
    {kind3, den_neg3, nb3, dmag3} = sq_side[SW];
    nbx = {{2{nb3[W]}}, nb3};
    sx  = {2'b00, sq_root[SW]};
    if (kind3 == qrs_pkg::KIND_COMPLEX) begin
      n1 = nbx;
      n2 = sx;
    end else begin
      n1 = nbx - sx;
      n2 = nbx + sx;
    end
    m1 = n1[W+2] ? -n1 : n1;
    m2 = n2[W+2] ? -n2 : n2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= sq_v[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num1_q   <= {m1[NMW-1:0], {FRAC_BITS{1'b0}}};
      num2_q   <= {m2[NMW-1:0], {FRAC_BITS{1'b0}}};
      dmag3_q  <= dmag3;
      side3a_q <= {kind3, n1[W+2] ^ den_neg3};
      neg2_q   <= n2[W+2] ^ den_neg3;
    end
  end

  // Divider chains, two lanes.
  logic           d1_v    [0:NW];
  logic [NW-1:0]  d1_numq [0:NW];
  logic [DW-1:0]  d1_rem  [0:NW];
  logic [DW-1:0]  d1_den  [0:NW];
  logic [L1W-1:0] d1_side [0:NW];
  logic           d2_v    [0:NW];
  logic [NW-1:0]  d2_numq [0:NW];
  logic [DW-1:0]  d2_rem  [0:NW];
  logic [DW-1:0]  d2_den  [0:NW];
  logic           d2_side [0:NW];

  assign d1_v[0]    = v3_q;
  assign d1_numq[0] = num1_q;
  assign d1_rem[0]  = '0;
  assign d1_den[0]  = dmag3_q;
  assign d1_side[0] = side3a_q;
  assign d2_v[0]    = v3_q;
  assign d2_numq[0] = num2_q;
  assign d2_rem[0]  = '0;
  assign d2_den[0]  = dmag3_q;
  assign d2_side[0] = neg2_q;

  for (genvar i = 0; i < NW; i++) begin : g_div
    qrs_div_cell #(
      .NumBits (NW),
      .DenBits (DW),
      .SideBits(L1W)
    ) u_lane1 (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(d1_v[i]),
      .numq_i (d1_numq[i]),
      .rem_i  (d1_rem[i]),
      .den_i  (d1_den[i]),
      .side_i (d1_side[i]),
      .valid_o(d1_v[i+1]),
      .numq_o (d1_numq[i+1]),
      .rem_o  (d1_rem[i+1]),
      .den_o  (d1_den[i+1]),
      .side_o (d1_side[i+1])
    );
    qrs_div_cell #(
      .NumBits (NW),
      .DenBits (DW),
      .SideBits(1)
    ) u_lane2 (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(d2_v[i]),
      .numq_i (d2_numq[i]),
      .rem_i  (d2_rem[i]),
      .den_i  (d2_den[i]),
      .side_i (d2_side[i]),
      .valid_o(d2_v[i+1]),
      .numq_o (d2_numq[i+1]),
      .rem_o  (d2_rem[i+1]),
      .den_o  (d2_den[i+1]),
      .side_o (d2_side[i+1])
    );
  end

  // Saturation and output register.
  logic [1:0]    kind4;
  logic          neg1, neg2, ov1, ov2, has_vals;
  logic [NW-1:0] lim1, lim2, q1, q2;
  logic [W-1:0]  r1, r2;

  logic [1:0]    kind_q;
  logic [W-1:0]  first_q, second_q;
  logic          sat_q;

  always_comb begin
    {kind4, neg1} = d1_side[NW];
    neg2     = d2_side[NW];
    has_vals = kind4 == qrs_pkg::KIND_REAL || kind4 == qrs_pkg::KIND_COMPLEX;
    lim1     = (NW'(1) << (W - 1)) - NW'(!neg1);
    lim2     = (NW'(1) << (W - 1)) - NW'(!neg2);
    ov1      = d1_numq[NW] > lim1;
    ov2      = d2_numq[NW] > lim2;
    q1       = ov1 ? lim1 : d1_numq[NW];
    q2       = ov2 ? lim2 : d2_numq[NW];
    r1       = neg1 ? -q1[W-1:0] : q1[W-1:0];
    r2       = neg2 ? -q2[W-1:0] : q2[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d1_v[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q   <= kind4;
      first_q  <= has_vals ? r1 : '0;
      second_q <= has_vals ? r2 : '0;
      sat_q    <= has_vals && (ov1 || ov2);
    end
  end

  assign root_o.valid        = out_valid_q;
  assign root_o.root_kind    = kind_q;
  assign root_o.first_value  = first_q;
  assign root_o.second_value = second_q;
  assign root_o.saturated    = sat_q;

endmodule

`default_nettype wire

### rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit step of a restoring square root: takes two radicand bits and
// settles one root bit, then hands everything to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell #(
  parameter int RootBits = 33,
  parameter int SideBits = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [2*RootBits-1:0] rad_i,
  input  wire logic [RootBits+2:0]   rem_i,
  input  wire logic [RootBits-1:0]   root_i,
  input  wire logic [SideBits-1:0]   side_i,
  output logic                       valid_o,
  output logic [2*RootBits-1:0]      rad_o,
  output logic [RootBits+2:0]        rem_o,
  output logic [RootBits-1:0]        root_o,
  output logic [SideBits-1:0]        side_o
);

  logic [RootBits+2:0] rem_sh;
  logic [RootBits+2:0] trial;
  logic                fits;

  always_comb begin
    rem_sh = {rem_i[RootBits:0], rad_i[2*RootBits-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*RootBits-3:0], 2'b00};
      rem_o  <= fits ? rem_sh - trial : rem_sh;
      root_o <= {root_i[RootBits-2:0], fits};
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

### rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// One step of a restoring unsigned divider: shifts in one dividend bit,
// subtracts the divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell #(
  parameter int NumBits  = 50,
  parameter int DenBits  = 33,
  parameter int SideBits = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [NumBits-1:0]  numq_i,
  input  wire logic [DenBits-1:0]  rem_i,
  input  wire logic [DenBits-1:0]  den_i,
  input  wire logic [SideBits-1:0] side_i,
  output logic                     valid_o,
  output logic [NumBits-1:0]       numq_o,
  output logic [DenBits-1:0]       rem_o,
  output logic [DenBits-1:0]       den_o,
  output logic [SideBits-1:0]      side_o
);

  logic [DenBits-1:0] part;
  logic               fits;

  always_comb begin
    part = {rem_i[DenBits-2:0], numq_i[NumBits-1]};
    fits = part >= den_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numq_o <= {numq_i[NumBits-2:0], fits};
      rem_o  <= fits ? part - den_i : part;
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire
